// ===== sv/mccdp_pkg.sv =====
// Package for the minimum coin count solver: widths, microcode format and program ROM.
`timescale 1ns / 1ps
`default_nettype none
package mccdp_pkg;

    localparam int DEF_MAX_AMOUNT = 16383;
    localparam int DEF_MAX_COINS  = 16;

    localparam int COIN_W = 16;
    localparam int TGT_W  = 14;
    localparam int CNT_W  = 15;

    localparam logic [CNT_W-1:0] UNREACH = {CNT_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CHECK2,
        S_INIT,
        S_SUM_BEGIN,
        S_RD_COIN,
        S_RD_TAB,
        S_UPD,
        S_WRITE,
        S_RES_TAB,
        S_RES_ZERO,
        S_RES_MISS,
        S_EMIT
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LASTACC,
        C_TZERO,
        C_TBIG,
        C_NOCOIN,
        C_KEND,
        C_SUMEND,
        C_OUTFREE
    } t_cond;

    typedef enum logic [1:0] {
        R_NONE,
        R_TAB,
        R_ZERO,
        R_MISS
    } t_res;

    typedef struct packed {
        t_cond cond;
        t_step jt;
        t_step jf;
        logic  accept;
        logic  init;
        logic  sum_begin;
        logic  rd_coin;
        logic  rd_tab;
        logic  upd;
        logic  wr_tab;
        t_res  res_sel;
        logic  emit;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE, accept: 1'b0, init: 1'b0,
              sum_begin: 1'b0, rd_coin: 1'b0, rd_tab: 1'b0, upd: 1'b0,
              wr_tab: 1'b0, res_sel: R_NONE, emit: 1'b0};
        case (step)
            S_IDLE: begin
                w.cond = C_LASTACC; w.jt = S_CHECK; w.jf = S_IDLE; w.accept = 1'b1;
            end
            S_CHECK: begin
                w.cond = C_TZERO; w.jt = S_RES_ZERO; w.jf = S_CHECK2;
            end
            S_CHECK2: begin
                w.cond = C_TBIG; w.jt = S_RES_MISS; w.jf = S_INIT;
            end
            S_INIT: begin
                w.cond = C_ALWAYS; w.jt = S_SUM_BEGIN; w.init = 1'b1;
            end
            S_SUM_BEGIN: begin
                w.cond = C_NOCOIN; w.jt = S_WRITE; w.jf = S_RD_COIN; w.sum_begin = 1'b1;
            end
            S_RD_COIN: begin
                w.cond = C_ALWAYS; w.jt = S_RD_TAB; w.rd_coin = 1'b1;
            end
            S_RD_TAB: begin
                w.cond = C_ALWAYS; w.jt = S_UPD; w.rd_tab = 1'b1;
            end
            S_UPD: begin
                w.cond = C_KEND; w.jt = S_WRITE; w.jf = S_RD_COIN; w.upd = 1'b1;
            end
            S_WRITE: begin
                w.cond = C_SUMEND; w.jt = S_RES_TAB; w.jf = S_SUM_BEGIN; w.wr_tab = 1'b1;
            end
            S_RES_TAB: begin
                w.cond = C_ALWAYS; w.jt = S_EMIT; w.res_sel = R_TAB;
            end
            S_RES_ZERO: begin
                w.cond = C_ALWAYS; w.jt = S_EMIT; w.res_sel = R_ZERO;
            end
            S_RES_MISS: begin
                w.cond = C_ALWAYS; w.jt = S_EMIT; w.res_sel = R_MISS;
            end
            S_EMIT: begin
                w.cond = C_OUTFREE; w.jt = S_IDLE; w.jf = S_EMIT; w.emit = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS; w.jt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== sv/min_coin_count_dp_top.sv =====
// Minimum coin count solver: microcoded sequencer over coin and count tables.
//
// Input channel (i_valid/o_ready) takes one coin per beat; the beat with
// i_last_coin set also carries i_target_amount and starts the solve. Zero
// coins are ignored; nonzero coins beyond MAX_COINS are dropped and flagged.
// Output channel (o_valid/i_ready) gives one beat per set: o_coin_count,
// o_found, o_coins_dropped.
// With target T (1..MAX_AMOUNT) and H stored coins the sequencer fills the
// count table for every sum from 1 to T: every sum walks every coin through
// a coin store read, a count table read and a compare, each one microcode
// step. Zero targets go straight to a found result of zero coins, and
// out-of-range targets to a not-found result.
// Input is taken only while the sequencer sits in its idle step; a result
// beat already waiting at the output does not block new coin beats.
// If the receiver stalls, the sequencer holds at its emit step until the
// output register frees up.
// Reset empties the coin set, clears the overflow flag and the output valid.
// The count table needs no clearing: each entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none
module min_coin_count_dp_top #(
    parameter int MAX_AMOUNT = mccdp_pkg::DEF_MAX_AMOUNT,
    parameter int MAX_COINS  = mccdp_pkg::DEF_MAX_COINS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [mccdp_pkg::COIN_W-1:0] i_coin_value,
    input  wire logic                         i_last_coin,
    input  wire logic [mccdp_pkg::TGT_W-1:0]  i_target_amount,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [mccdp_pkg::TGT_W-1:0]       o_coin_count,
    output logic                              o_found,
    output logic                              o_coins_dropped
);

    localparam int AW   = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
    localparam int KW   = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int HW   = $clog2(MAX_COINS + 1);
    localparam int CMPW = (AW > mccdp_pkg::TGT_W) ? AW : mccdp_pkg::TGT_W;
    localparam int CW   = mccdp_pkg::CNT_W;

    logic [mccdp_pkg::COIN_W-1:0] coin_mem [MAX_COINS];
    logic [CW-1:0]                tab_mem  [MAX_AMOUNT + 1];

    mccdp_pkg::t_step  r_pc, n_pc;
    mccdp_pkg::t_uword uw;
    logic              cond_true;
    logic              in_acc;
    logic              out_free;
    logic              coin_fit;

    logic [HW-1:0]                r_held;
    logic                         r_ovf;
    logic [HW-1:0]                r_k;
    logic [AW-1:0]                r_sum;
    logic [mccdp_pkg::TGT_W-1:0]  r_target;
    logic [CW-1:0]                r_best;
    logic [mccdp_pkg::COIN_W-1:0] r_coin;
    logic [CW-1:0]                r_tdata;
    logic                         r_fit;
    logic [mccdp_pkg::TGT_W-1:0]  r_res_count;
    logic                         r_res_found;
    logic                         r_out_valid;
    logic [mccdp_pkg::TGT_W-1:0]  r_out_count;
    logic                         r_out_found;
    logic                         r_out_drop;

    logic                         tab_we;
    logic [AW-1:0]                tab_waddr;
    logic [CW-1:0]                tab_wdata;
    logic [AW-1:0]                tab_raddr;
    logic [CW-1:0]                best_cand;

    always_comb begin
        uw        = mccdp_pkg::ucode(r_pc);
        in_acc    = i_valid && uw.accept;
        out_free  = !r_out_valid || i_ready;
        coin_fit  = (r_coin != '0) && (r_coin <= mccdp_pkg::COIN_W'(r_sum));
        tab_raddr = AW'(mccdp_pkg::COIN_W'(r_sum) - r_coin);
        tab_we    = uw.init || uw.wr_tab;
        tab_waddr = uw.init ? '0 : r_sum;
        tab_wdata = uw.init ? '0 : r_best;
        best_cand = r_tdata + CW'(1);
        case (uw.cond)
            mccdp_pkg::C_ALWAYS:  cond_true = 1'b1;
            mccdp_pkg::C_LASTACC: cond_true = in_acc && i_last_coin;
            mccdp_pkg::C_TZERO:   cond_true = (r_target == '0);
            mccdp_pkg::C_TBIG:    cond_true = (32'(r_target) > 32'(MAX_AMOUNT));
            mccdp_pkg::C_NOCOIN:  cond_true = (r_held == '0);
            mccdp_pkg::C_KEND:    cond_true = (r_k == r_held);
            mccdp_pkg::C_SUMEND:  cond_true = (CMPW'(r_sum) == CMPW'(r_target));
            mccdp_pkg::C_OUTFREE: cond_true = out_free;
            default:              cond_true = 1'b0;
        endcase
        n_pc = cond_true ? uw.jt : uw.jf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mccdp_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // coin set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_ovf  <= 1'b0;
        end else if (uw.emit && out_free) begin
            r_held <= '0;
            r_ovf  <= 1'b0;
        end else if (in_acc && (i_coin_value != '0)) begin
            if (r_held < HW'(MAX_COINS)) begin
                r_held <= r_held + HW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_coin_value != '0) && (r_held < HW'(MAX_COINS))) begin
            coin_mem[r_held[KW-1:0]] <= i_coin_value;
        end
        if (uw.rd_coin) begin
            r_coin <= coin_mem[r_k[KW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (uw.rd_tab && coin_fit) begin
            r_tdata <= tab_mem[tab_raddr];
        end
    end

    // datapath driven by the control word
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_coin) begin
            r_target <= i_target_amount;
        end
        if (uw.init) begin
            r_sum <= AW'(1);
        end else if (uw.wr_tab) begin
            r_sum <= r_sum + AW'(1);
        end
        if (uw.sum_begin) begin
            r_best <= mccdp_pkg::UNREACH;
            r_k    <= '0;
        end
        if (uw.rd_tab) begin
            r_fit <= coin_fit;
            r_k   <= r_k + HW'(1);
        end
        if (uw.upd && r_fit && (r_tdata != mccdp_pkg::UNREACH) && (best_cand < r_best)) begin
            r_best <= best_cand;
        end
        case (uw.res_sel)
            mccdp_pkg::R_TAB: begin
                r_res_found <= (r_best != mccdp_pkg::UNREACH);
                r_res_count <= (r_best != mccdp_pkg::UNREACH) ?
                               r_best[mccdp_pkg::TGT_W-1:0] : '0;
            end
            mccdp_pkg::R_ZERO: begin
                r_res_found <= 1'b1;
                r_res_count <= '0;
            end
            mccdp_pkg::R_MISS: begin
                r_res_found <= 1'b0;
                r_res_count <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit && out_free) begin
            r_out_count <= r_res_count;
            r_out_found <= r_res_found;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_ready         = uw.accept;
    assign o_valid         = r_out_valid;
    assign o_coin_count    = r_out_count;
    assign o_found         = r_out_found;
    assign o_coins_dropped = r_out_drop;

`ifndef ASSERT_OFF
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= 32'(MAX_COINS))
        else $error("coin count exceeds store depth");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == mccdp_pkg::S_EMIT && out_free) |=>
            (o_valid && r_pc == mccdp_pkg::S_IDLE && r_held == '0 && !r_ovf))
        else $error("result beat not loaded or coin set not cleared");

    a_best_le_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.wr_tab && r_best != mccdp_pkg::UNREACH) |-> (32'(r_best) <= 32'(r_sum)))
        else $error("best count exceeds the sum");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_coin_count == '0))
        else $error("nonzero count on a miss");
`endif

endmodule
`default_nettype wire
